// ===== rtl/core/pidsw_pkg.sv =====
// shared types and constants of the weighted-setpoint pid controller
package pidsw_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_GAIN = 3'd0;
    localparam logic [2:0] REG_TI   = 3'd1;
    localparam logic [2:0] REG_TD   = 3'd2;
    localparam logic [2:0] REG_B    = 3'd3;
    localparam logic [2:0] REG_N    = 3'd4;
    localparam logic [2:0] REG_TP   = 3'd5;

    // operation codes of the shared arithmetic unit
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_ADD,
        OP_SUB
    } alu_op_t;

endpackage

// ===== rtl/core/pidsw_alu.sv =====
// shared saturating fixed-point unit: bit-serial multiply and divide, add, subtract
module pidsw_alu #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  pidsw_pkg::alu_op_t           op,
    input  logic signed [DATA_WIDTH-1:0] opa,
    input  logic signed [DATA_WIDTH-1:0] opb,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] res
);
    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W + FRAC_BITS;
    localparam int CW = $clog2(PW + 1);
    localparam logic [W:0] MAXP = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0] MAXN = {2'b01, {(W-1){1'b0}}};

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} st_t;

    st_t              state_reg;
    logic [CW-1:0]    cnt_reg;
    logic             neg_reg;
    logic [W-1:0]     ma_reg, mb_reg;
    logic [PW-1:0]    acc_reg;
    logic [W:0]       rem_reg;
    logic [PW-1:0]    num_reg;
    logic signed [W-1:0] res_reg;

    logic [W-1:0] mag_a, mag_b;
    logic [W:0]   rsh, rdf;
    logic signed [W+1:0] sum_ext;
    logic [PW-1:0] add_sh;

    assign mag_a = opa[W-1] ? (~opa + 1'b1) : opa;
    assign mag_b = opb[W-1] ? (~opb + 1'b1) : opb;
    assign sum_ext = (op == pidsw_pkg::OP_ADD) ?
        ({{2{opa[W-1]}}, opa} + {{2{opb[W-1]}}, opb}) :
        ({{2{opa[W-1]}}, opa} - {{2{opb[W-1]}}, opb});
    // multiply: add shifted multiplicand for each multiplier bit
    assign add_sh = ma_reg[0] ? (acc_reg + ({{(PW-W){1'b0}}, mb_reg} << cnt_reg)) : acc_reg;
    // divide: one restoring step per cycle
    assign rsh = {rem_reg[W-1:0], num_reg[PW-1]};
    assign rdf = rsh - {1'b0, mb_reg};

    // saturate a magnitude with sign
    function automatic logic [W-1:0] sat(input logic neg, input logic [PW-1:0] m);
        logic [PW-1:0] lim;
        lim = {{(PW-W-1){1'b0}}, neg ? MAXN : MAXP};
        if (m > lim) m = lim;
        sat = neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
    endfunction

    assign done = (state_reg == S_DONE);
    assign res  = res_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        neg_reg <= opa[W-1] ^ opb[W-1];
                        ma_reg  <= mag_a;
                        mb_reg  <= mag_b;
                        acc_reg <= '0;
                        rem_reg <= '0;
                        num_reg <= {{(PW-W){1'b0}}, mag_a} << FRAC_BITS;
                        cnt_reg <= '0;
                        unique case (op)
                            pidsw_pkg::OP_MUL: state_reg <= S_MUL;
                            pidsw_pkg::OP_DIV: state_reg <= S_DIV;
                            default: begin
                                if (sum_ext > $signed({2'b00, MAXP[W-1:0]}))
                                    res_reg <= MAXP[W-1:0];
                                else if (sum_ext < -$signed({1'b0, MAXN}))
                                    res_reg <= MAXN[W-1:0];
                                else
                                    res_reg <= sum_ext[W-1:0];
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    acc_reg <= add_sh;
                    ma_reg  <= ma_reg >> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(W - 1)) begin
                        res_reg   <= sat(neg_reg, add_sh >> FRAC_BITS);
                        state_reg <= S_DONE;
                    end
                end
                S_DIV: begin
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (!rdf[W]) begin
                        rem_reg <= rdf;
                        acc_reg <= {acc_reg[PW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rsh;
                        acc_reg <= {acc_reg[PW-2:0], 1'b0};
                    end
                    if (cnt_reg == CW'(PW - 1)) begin
                        res_reg   <= sat(neg_reg, {acc_reg[PW-2:0], ~rdf[W]});
                        state_reg <= S_DONE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/pid_setpoint_weighted_filtered_d.sv =====
// top level of the weighted-setpoint pid controller with filtered derivative
// Usage: write the six gain/time registers through cfg_* while idle. Each
// s_axis word (setpoint low, measured high) yields one m_axis word
// (control, divide_fault in bit 32). Work runs through one shared
// saturating unit, with bit-serial multiplies and divides. A sample
// issues at most 9 multiplies, 2 divides and 8 add/sub, and fewer
// when Ti or Td is zero; the shared serial unit sets the sample pace.
// One item is worked on at a time; s_axis_tready is high only when
// the controller is idle and the output register empty.
// A stalled m_axis holds the result; no new sample is taken until it
// leaves. Reset clears the integrator, filter, history and error state.
module pid_setpoint_weighted_filtered_d #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // setpoint[31:0], measured[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // control[31:0], divide_fault[32]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int W = DATA_WIDTH;
    typedef logic signed [W-1:0] d_t;

    typedef enum logic [4:0] {
        S_IDLE, S_P1, S_P2, S_P3, S_I1, S_I2, S_I3, S_I4,
        S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_D8, S_D9,
        S_C1, S_C2, S_E, S_OUT
    } st_t;

    logic [31:0] k_reg, b_reg;
    logic [30:0] ti_reg, td_reg, n_reg, tp_reg;
    st_t  state_reg;
    d_t   iacc_reg, dacc_reg, y_reg, yp_reg, e_reg, w_reg;
    d_t   p_reg, t1_reg, t2_reg, c_reg;
    logic fault_reg;
    logic [31:0] ctl_reg;
    logic        ovalid_reg;

    logic alu_start, alu_done;
    pidsw_pkg::alu_op_t alu_op;
    d_t alu_a, alu_b, alu_r;
    logic busy_reg;

    // clamp a 32-bit signed value into the data width
    function automatic d_t cl32(input logic [31:0] v);
        logic signed [63:0] x;
        logic signed [63:0] hi;
        x  = {{32{v[31]}}, v};
        hi = (64'sd1 <<< (W - 1)) - 64'sd1;
        if (x > hi) x = hi;
        else if (x < -hi - 64'sd1) x = -hi - 64'sd1;
        cl32 = x[W-1:0];
    endfunction

    function automatic d_t cl31(input logic [30:0] v);
        cl31 = cl32({1'b0, v});
    endfunction

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, fault_reg, ctl_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= 32'd65536;  ti_reg <= '0; td_reg <= '0;
            b_reg <= 32'd65536;  n_reg <= 31'd655360; tp_reg <= 31'd65536;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pidsw_pkg::REG_GAIN: k_reg  <= cfg_data;
                pidsw_pkg::REG_TI:   ti_reg <= cfg_data[30:0];
                pidsw_pkg::REG_TD:   td_reg <= cfg_data[30:0];
                pidsw_pkg::REG_B:    b_reg  <= cfg_data;
                pidsw_pkg::REG_N:    n_reg  <= cfg_data[30:0];
                pidsw_pkg::REG_TP:   tp_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // operand selection per step
    always_comb begin
        alu_op = pidsw_pkg::OP_MUL; alu_a = '0; alu_b = '0;
        unique case (state_reg)
            S_P1: begin alu_a = cl32(b_reg); alu_b = w_reg; end
            S_P2: begin alu_op = pidsw_pkg::OP_SUB; alu_a = t1_reg; alu_b = y_reg; end
            S_P3: begin alu_a = cl32(k_reg); alu_b = t1_reg; end
            S_I1: begin alu_a = cl32(k_reg); alu_b = cl31(tp_reg); end
            S_I2: begin alu_a = t1_reg; alu_b = e_reg; end
            S_I3: begin alu_op = pidsw_pkg::OP_DIV; alu_a = t1_reg; alu_b = cl31(ti_reg); end
            S_I4: begin alu_op = pidsw_pkg::OP_ADD; alu_a = iacc_reg; alu_b = t1_reg; end
            S_D1: begin alu_a = cl31(n_reg); alu_b = cl31(tp_reg); end
            S_D2: begin alu_op = pidsw_pkg::OP_ADD; alu_a = t1_reg; alu_b = cl31(td_reg); end
            S_D3: begin alu_op = pidsw_pkg::OP_DIV; alu_a = cl31(td_reg); alu_b = t1_reg; end
            S_D4: begin alu_op = pidsw_pkg::OP_SUB; alu_a = y_reg; alu_b = yp_reg; end
            S_D5: begin alu_a = cl32(k_reg); alu_b = cl31(n_reg); end
            S_D6: begin alu_a = t1_reg; alu_b = t2_reg; end
            S_D7: begin alu_a = t1_reg; alu_b = c_reg; end
            S_D8: begin alu_a = dacc_reg; alu_b = c_reg; end
            S_D9: begin alu_op = pidsw_pkg::OP_SUB; alu_a = t1_reg; alu_b = t2_reg; end
            S_C1: begin alu_op = pidsw_pkg::OP_ADD; alu_a = p_reg; alu_b = iacc_reg; end
            S_C2: begin alu_op = pidsw_pkg::OP_ADD; alu_a = t1_reg; alu_b = dacc_reg; end
            S_E:  begin alu_op = pidsw_pkg::OP_SUB; alu_a = w_reg; alu_b = y_reg; end
            default: ;
        endcase
    end

    assign alu_start = !busy_reg && state_reg != S_IDLE && state_reg != S_OUT;

    pidsw_alu #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_alu (
        .aclk(aclk), .aresetn(aresetn), .start(alu_start), .op(alu_op),
        .opa(alu_a), .opb(alu_b), .done(alu_done), .res(alu_r)
    );

    // control sequencer and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            iacc_reg <= '0; dacc_reg <= '0; y_reg <= '0; yp_reg <= '0; e_reg <= '0;
        end else begin
            if (ovalid_reg && m_axis_tready) ovalid_reg <= 1'b0;
            if (alu_start) busy_reg <= 1'b1;
            if (alu_done)  busy_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    w_reg     <= cl32(s_axis_tdata[31:0]);
                    yp_reg    <= y_reg;
                    y_reg     <= cl32(s_axis_tdata[63:32]);
                    fault_reg <= 1'b0;
                    state_reg <= S_P1;
                end
                S_OUT: begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: if (alu_done) begin
                    t1_reg <= alu_r;
                    unique case (state_reg)
                        S_P1: state_reg <= S_P2;
                        S_P2: state_reg <= S_P3;
                        S_P3: begin
                            p_reg <= alu_r;
                            if (ti_reg == '0) begin
                                iacc_reg <= '0;
                                if (td_reg == '0) begin
                                    dacc_reg <= '0; state_reg <= S_C1;
                                end else state_reg <= S_D1;
                            end else state_reg <= S_I1;
                        end
                        S_I1: state_reg <= S_I2;
                        S_I2: state_reg <= S_I3;
                        S_I3: state_reg <= S_I4;
                        S_I4: begin
                            iacc_reg <= alu_r;
                            if (td_reg == '0) begin
                                dacc_reg <= '0; state_reg <= S_C1;
                            end else state_reg <= S_D1;
                        end
                        S_D1: state_reg <= S_D2;
                        S_D2: begin
                            if (alu_r == '0) begin
                                fault_reg <= 1'b1; state_reg <= S_C1;
                            end else state_reg <= S_D3;
                        end
                        S_D3: begin c_reg <= alu_r; state_reg <= S_D4; end
                        S_D4: begin t2_reg <= alu_r; state_reg <= S_D5; end
                        S_D5: state_reg <= S_D6;
                        S_D6: state_reg <= S_D7;
                        S_D7: begin t2_reg <= alu_r; state_reg <= S_D8; end
                        S_D8: state_reg <= S_D9;
                        S_D9: begin dacc_reg <= alu_r; state_reg <= S_C1; end
                        S_C1: state_reg <= S_C2;
                        S_C2: begin
                            if (alu_r > $signed(64'sd2147483647))
                                ctl_reg <= 32'h7fffffff;
                            else if (alu_r < $signed(-64'sd2147483648))
                                ctl_reg <= 32'h80000000;
                            else
                                ctl_reg <= 32'(alu_r);
                            state_reg <= S_E;
                        end
                        S_E: begin e_reg <= alu_r; state_reg <= S_OUT; end
                        default: state_reg <= S_IDLE;
                    endcase
                end
            endcase
        end
    end
endmodule

// ===== tb/tb.sv =====
// testbench of the weighted-setpoint pid controller with filtered derivative
`timescale 1ns / 100ps

module tb;

    localparam int  LATENCY_WAIT = 800;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  PHASES       = 8;
    localparam int  PHASE_WORDS  = 50;
    localparam longint Q_ONE     = 65536;

    typedef struct packed {
        logic [31:0] control;
        logic        fault;
    } ctl_word_t;

    typedef struct {
        logic [31:0] setpoint;
        logic [31:0] measured;
        bit          typed;
        logic [31:0] control;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // setpoint[31:0], measured[63:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // control[31:0], divide_fault[32]
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = pidsw_pkg::REG_GAIN;
    logic [31:0] cfg_data = '0;

    pid_setpoint_weighted_filtered_d dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // controller copy: registers and state
    logic [31:0] k_reg, ti_reg, td_reg, b_reg, n_reg, tp_reg;
    longint integ_acc, deriv_acc, y_now, y_last, err_last;

    ctl_word_t control_q[$];
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int cycles = 0;

    // saturating fixed point helpers at 32 bits
    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fmul(longint a, longint b);
        longint ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma * mb) >>> 16;
        return sat32(((a < 0) != (b < 0)) ? -m : m);
    endfunction

    function automatic longint fdiv(longint a, longint b);
        longint ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma <<< 16) / mb;
        return sat32(((a < 0) != (b < 0)) ? -m : m);
    endfunction

    function automatic longint sx(logic [31:0] x);
        return longint'($signed(x));
    endfunction

    function automatic longint ux(logic [31:0] x);
        return longint'({33'b0, x[30:0]});
    endfunction

    // one controller step: updates the state, returns the output word
    function automatic ctl_word_t pid_step(logic [31:0] w32, logic [31:0] y32);
        longint k, b, ti, td, n, tp, w, y, p, den, c, dy, ctl;
        ctl_word_t r;
        k = sx(k_reg); b = sx(b_reg);
        ti = ux(ti_reg); td = ux(td_reg); n = ux(n_reg); tp = ux(tp_reg);
        w = sx(w32); y = sx(y32);
        r.fault = 1'b0;
        y_last = y_now;
        y_now = y;
        p = fmul(k, sat32(fmul(b, w) - y));
        if (ti == 0)
            integ_acc = 0;
        else
            integ_acc = sat32(integ_acc + fdiv(fmul(fmul(k, tp), err_last), ti));
        if (td == 0) begin
            deriv_acc = 0;
        end else begin
            den = sat32(fmul(n, tp) + td);
            if (den == 0) begin
                r.fault = 1'b1;
            end else begin
                c = fdiv(td, den);
                dy = sat32(y_now - y_last);
                deriv_acc = sat32(fmul(deriv_acc, c) - fmul(fmul(fmul(k, n), dy), c));
            end
        end
        ctl = sat32(sat32(p + integ_acc) + deriv_acc);
        err_last = sat32(w - y);
        r.control = ctl[31:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h (word %0d)", what, got, want,
                 words_checked);
        errors++;
    endtask

    // register write, applied at the next edge
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            pidsw_pkg::REG_GAIN: k_reg = val;
            pidsw_pkg::REG_TI:   ti_reg = val;
            pidsw_pkg::REG_TD:   td_reg = val;
            pidsw_pkg::REG_B:    b_reg = val;
            pidsw_pkg::REG_N:    n_reg = val;
            pidsw_pkg::REG_TP:   tp_reg = val;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] k, logic [31:0] ti, logic [31:0] td,
                             logic [31:0] b, logic [31:0] n, logic [31:0] tp);
        write_reg(pidsw_pkg::REG_GAIN, k);
        write_reg(pidsw_pkg::REG_TI, ti);
        write_reg(pidsw_pkg::REG_TD, td);
        write_reg(pidsw_pkg::REG_B, b);
        write_reg(pidsw_pkg::REG_N, n);
        write_reg(pidsw_pkg::REG_TP, tp);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one word; predicts on acceptance
    task automatic send_word(logic [31:0] w, logic [31:0] y, bit typed,
                             logic [31:0] typed_ctl);
        int gap;
        ctl_word_t want;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, w};
        do @(posedge aclk); while (!s_axis_tready);
        want = pid_step(w, y);
        if (typed) want.control = typed_ctl;
        control_q.push_back(want);
        words_sent++;
    endtask

    task automatic wait_idle();
        while (control_q.size() != 0) @(posedge aclk);
    endtask

    // signed Q16.16 operand: mostly moderate, sometimes any value or an extreme
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: case ($urandom_range(0, 3))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'h0;
                default: return 32'hffff_ffff;
            endcase
            default: return $urandom_range(0, 32 * 65536) - 16 * 65536;
        endcase
    endfunction

    // unsigned time-like register: moderate, zero, one lsb or full range
    function automatic logic [31:0] rand_time(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return $urandom;
            2: return 32'h7fff_ffff;
            3: return 32'h1;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // result side: stalls, check against oldest expectation
    int stall_left = 0;
    bit no_stall = 1'b0;
    always @(posedge aclk) begin
        ctl_word_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (control_q.size() == 0) begin
                $display("unexpected output word %h", m_axis_tdata);
                errors++;
            end else begin
                want = control_q.pop_front();
                if (m_axis_tdata[31:0] !== want.control)
                    report("control", m_axis_tdata[31:0], want.control);
                if (m_axis_tdata[32] !== want.fault)
                    report("divide_fault", {31'b0, m_axis_tdata[32]},
                           {31'b0, want.fault});
                words_checked++;
            end
        end
        if ($urandom_range(0, 199) == 0) no_stall = !no_stall;
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!no_stall && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("pid_setpoint_weighted_filtered_d test failed");
            $finish;
        end
    end

    stim_row_t rows[$];

    initial begin
        // register state after reset
        k_reg = 32'(Q_ONE); ti_reg = 0; td_reg = 0; b_reg = 32'(Q_ONE);
        n_reg = 32'(10 * Q_ONE); tp_reg = 32'(Q_ONE);
        integ_acc = 0; deriv_acc = 0; y_now = 0; y_last = 0; err_last = 0;

        // directed rows under reset defaults: control is w - y, saturated
        rows.push_back('{32'h0, 32'h0, 1, 32'h0});
        rows.push_back('{32'h7fff_ffff, 32'h8000_0000, 1, 32'h7fff_ffff});
        rows.push_back('{32'h8000_0000, 32'h7fff_ffff, 1, 32'h8000_0000});
        rows.push_back('{32'h0005_0000, 32'h0002_0000, 1, 32'h0003_0000});
        rows.push_back('{32'hffff_0000, 32'h0000_8000, 1, 32'hfffe_8000});
        rows.push_back('{32'hffff_ffff, 32'hffff_ffff, 1, 32'h0});
        rows.push_back('{32'h1234_5678, 32'hedcb_a987, 0, 32'h0});
        rows.push_back('{32'h0001_0000, 32'h7fff_0000, 0, 32'h0});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            send_word(rows[i].setpoint, rows[i].measured, rows[i].typed,
                      rows[i].control);
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            // extremes first, then a fixed moderate setting, then random settings
            case (ph)
                0: write_all(32'h7fff_ffff, 32'h1, 32'h7fff_ffff,
                             32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
                1: write_all(32'h8000_0000, 32'h7fff_ffff, 32'h1,
                             32'h0, 32'h0, 32'h0);
                2: write_all(32'h0002_0000, 32'h0004_0000, 32'h0001_0000,
                             32'h0000_8000, 32'h000a_0000, 32'h0000_1999);
                default: write_all(rand_value(), rand_time(16384, 8 * 65536),
                                   rand_time(0, 4 * 65536), rand_value(),
                                   rand_time(0, 20 * 65536), rand_time(655, 65536));
            endcase
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(rand_value(), rand_value(), 0, 32'h0);
            s_axis_tvalid <= 1'b0;
        end

        wait_idle();
        repeat (LATENCY_WAIT) @(posedge aclk);

        $display("sent %0d words and checked %0d results over %0d register settings",
                 words_sent, words_checked, PHASES + 1);
        $display("covered saturation extremes, integral and filtered derivative paths");
        if (errors == 0 && control_q.size() == 0)
            $display("pid_setpoint_weighted_filtered_d test passed");
        else
            $display("pid_setpoint_weighted_filtered_d test failed");
        $finish;
    end

endmodule

// ===== pid_setpoint_weighted_filtered_d.f =====
rtl/core/pidsw_pkg.sv
rtl/core/pidsw_alu.sv
rtl/core/pid_setpoint_weighted_filtered_d.sv
tb/tb.sv
